// ===== rtl/wstq_pkg.sv =====
// shared types and codes for the work stealing task queues
package wstq_pkg;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int CSR_BITS = 4;
   localparam logic [CSR_BITS-1:0] ACTIVE_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUBMIT,
      ST_PROBE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  worker_index;
      logic [15:0] task_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] task_out;
      logic [2:0]  source_queue;
      logic        was_stolen;
      logic [7:0]  pending_count;
   } rsp_type;

endpackage

// ===== rtl/wstq_ram.sv =====
// generic single port ram with registered read
module wstq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/wstq_slot.sv =====
// slot address unit: queue base plus ring position wrapped at the queue depth
module wstq_slot #(
   parameter int MAX_WORKERS = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic [$clog2(MAX_WORKERS)-1:0]             queue,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]             head,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]           offset,
   output logic [$clog2(MAX_WORKERS*QUEUE_DEPTH)-1:0] slot
);

   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = $clog2(MAX_WORKERS * QUEUE_DEPTH);

   logic [FW:0]   sum;
   logic [FW:0]   wrapped;
   logic [HW-1:0] pos;

   always_comb begin
      sum = (FW+1)'(head) + (FW+1)'(offset);
      if (sum >= (FW+1)'(QUEUE_DEPTH)) begin
         wrapped = sum - (FW+1)'(QUEUE_DEPTH);
      end else begin
         wrapped = sum;
      end
      pos  = HW'(wrapped);
      slot = SW'(queue) * SW'(QUEUE_DEPTH) + SW'(pos);
   end

endmodule

// ===== rtl/work_stealing_task_queues.sv =====
// work stealing task queues: per worker deques, round-robin submit, fetch with stealing
// a submit passes ST_SUBMIT; a fetch probes its own queue, then other active ones, and
//   reads in ST_READ; busy is high until the result, and no command is taken while busy;
//   an inactive worker's fetch answers empty from idle without busy; one queue probed per
//   cycle by one shared slot unit; the result strobe lasts one cycle and cannot be stalled
// reset clears all queues, the round-robin counter and the pending count; no clearing pass
module work_stealing_task_queues #(
   parameter int MAX_WORKERS = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int TASK_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  wstq_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output wstq_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [wstq_pkg::CSR_BITS-1:0]    csr_wdata
);

   localparam int QW    = $clog2(MAX_WORKERS);
   localparam int AW    = $clog2(MAX_WORKERS + 1);
   localparam int HW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS = MAX_WORKERS * QUEUE_DEPTH;
   localparam int SW    = $clog2(SLOTS);
   localparam int PW    = $clog2(SLOTS + 1);

   wstq_pkg::state_type state_ff, state_in;
   logic [wstq_pkg::CSR_BITS-1:0] cfg_ff, cfg_in;
   logic [AW-1:0] act_ff, act_in;
   wstq_pkg::req_type req_ff, req_in;
   logic [QW-1:0] cur_ff, cur_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [QW-1:0] rr_ff, rr_in;
   logic [HW-1:0] head_ff [MAX_WORKERS];
   logic [HW-1:0] head_in [MAX_WORKERS];
   logic [FW-1:0] fill_ff [MAX_WORKERS];
   logic [FW-1:0] fill_in [MAX_WORKERS];
   logic [PW-1:0] pending_ff, pending_in;
   logic stolen_ff, stolen_in;
   logic rsp_valid_ff, rsp_valid_in;
   wstq_pkg::rsp_type rsp_ff, rsp_in;

   logic          accept;
   logic [AW-1:0] act_now;
   logic [7:0]    cfg_ext;
   logic          worker_ok;
   logic [HW-1:0] cur_head;
   logic [FW-1:0] cur_fill;
   logic [AW-1:0] cur_plus;
   logic [QW-1:0] cur_wrap;
   logic          own_hit;
   logic          scan_done;
   logic          steal_hit;
   logic [QW-1:0] rr_pick;
   logic [AW-1:0] rr_plus;
   logic [FW-1:0] offset;
   logic [SW-1:0] slot;
   logic          ram_we;
   logic [TASK_BITS-1:0] ram_wdata;
   logic [TASK_BITS-1:0] ram_rdata;
   logic [63:0]   rd_ext;

   function automatic logic [7:0] sat8(input logic [PW-1:0] value);
      logic [31:0] wide;
      wide = 32'(value);
      if (wide > 32'd255) begin
         return 8'hff;
      end
      return wide[7:0];
   endfunction

   // active worker count with out of range values clamped
   always_comb begin
      cfg_ext = 8'(cfg_ff);
      if (cfg_ff == '0) begin
         act_now = AW'(1);
      end else if (cfg_ext > 8'(MAX_WORKERS)) begin
         act_now = AW'(MAX_WORKERS);
      end else begin
         act_now = AW'(cfg_ff);
      end
   end

   assign accept    = start && !busy;
   assign busy      = (state_ff != wstq_pkg::ST_IDLE);
   assign worker_ok = 8'(req_data.worker_index) < 8'(act_now);

   assign cur_head = head_ff[cur_ff];
   assign cur_fill = fill_ff[cur_ff];
   assign cur_plus = AW'(cur_ff) + AW'(1);
   assign cur_wrap = (cur_plus >= act_ff) ? '0 : QW'(cur_plus);

   assign own_hit   = (scan_ff == '0) && (cur_fill != '0);
   assign scan_done = (scan_ff != '0) && (scan_ff >= act_ff);
   assign steal_hit = (scan_ff != '0) && !scan_done && (cur_fill != '0);

   assign rr_pick = (AW'(rr_ff) < act_now) ? rr_ff : '0;
   assign rr_plus = AW'(rr_pick) + AW'(1);

   assign ram_wdata = TASK_BITS'({48'd0, req_ff.task_id});
   assign rd_ext    = 64'(ram_rdata);

   wstq_slot #(
      .MAX_WORKERS (MAX_WORKERS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_slot (
      .queue  (cur_ff),
      .head   (cur_head),
      .offset (offset),
      .slot   (slot)
   );

   wstq_ram #(
      .WIDTH (TASK_BITS),
      .DEPTH (SLOTS)
   ) u_task_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (slot),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wstq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == wstq_pkg::CMD_SUBMIT) begin
                  state_in = wstq_pkg::ST_SUBMIT;
               end else if (worker_ok) begin
                  state_in = wstq_pkg::ST_PROBE;
               end
            end
         end
         wstq_pkg::ST_SUBMIT: begin
            state_in = wstq_pkg::ST_IDLE;
         end
         wstq_pkg::ST_PROBE: begin
            if (own_hit || steal_hit) begin
               state_in = wstq_pkg::ST_READ;
            end else if (scan_done) begin
               state_in = wstq_pkg::ST_IDLE;
            end
         end
         wstq_pkg::ST_READ: begin
            state_in = wstq_pkg::ST_IDLE;
         end
         default: begin
            state_in = wstq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cfg_in       = csr_we ? csr_wdata : cfg_ff;
      act_in       = act_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      rr_in        = rr_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      pending_in   = pending_ff;
      stolen_in    = stolen_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      offset       = '0;
      case (state_ff)
         wstq_pkg::ST_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               act_in    = act_now;
               scan_in   = '0;
               stolen_in = 1'b0;
               if (req_data.cmd == wstq_pkg::CMD_SUBMIT) begin
                  cur_in = rr_pick;
                  rr_in  = (rr_plus >= act_now) ? '0 : QW'(rr_plus);
               end else if (worker_ok) begin
                  cur_in = QW'(8'(req_data.worker_index));
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = wstq_pkg::STATUS_EMPTY;
                  rsp_in.task_out      = '0;
                  rsp_in.source_queue  = '0;
                  rsp_in.was_stolen    = 1'b0;
                  rsp_in.pending_count = sat8(pending_ff);
               end
            end
         end
         wstq_pkg::ST_SUBMIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.task_out     = '0;
            rsp_in.source_queue = 3'(cur_ff);
            rsp_in.was_stolen   = 1'b0;
            if (cur_fill >= FW'(QUEUE_DEPTH)) begin
               rsp_in.status        = wstq_pkg::STATUS_FULL;
               rsp_in.pending_count = sat8(pending_ff);
            end else begin
               ram_we               = 1'b1;
               offset               = cur_fill;
               fill_in[cur_ff]      = cur_fill + FW'(1);
               pending_in           = pending_ff + PW'(1);
               rsp_in.status        = wstq_pkg::STATUS_DONE;
               rsp_in.pending_count = sat8(pending_ff + PW'(1));
            end
         end
         wstq_pkg::ST_PROBE: begin
            if (own_hit) begin
               offset          = cur_fill - FW'(1);
               fill_in[cur_ff] = cur_fill - FW'(1);
               pending_in      = pending_ff - PW'(1);
               stolen_in       = 1'b0;
            end else if (scan_done) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = wstq_pkg::STATUS_EMPTY;
               rsp_in.task_out      = '0;
               rsp_in.source_queue  = '0;
               rsp_in.was_stolen    = 1'b0;
               rsp_in.pending_count = sat8(pending_ff);
            end else if (steal_hit) begin
               offset          = '0;
               head_in[cur_ff] = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + HW'(1);
               fill_in[cur_ff] = cur_fill - FW'(1);
               pending_in      = pending_ff - PW'(1);
               stolen_in       = 1'b1;
            end else begin
               scan_in = scan_ff + AW'(1);
               cur_in  = cur_wrap;
            end
         end
         wstq_pkg::ST_READ: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = wstq_pkg::STATUS_DONE;
            rsp_in.task_out      = rd_ext[15:0];
            rsp_in.source_queue  = 3'(cur_ff);
            rsp_in.was_stolen    = stolen_ff;
            rsp_in.pending_count = sat8(pending_ff);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wstq_pkg::ST_IDLE;
         cfg_ff       <= wstq_pkg::ACTIVE_RESET;
         scan_ff      <= '0;
         rr_ff        <= '0;
         pending_ff   <= '0;
         stolen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_WORKERS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         scan_ff      <= scan_in;
         rr_ff        <= rr_in;
         pending_ff   <= pending_in;
         stolen_ff    <= stolen_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      req_ff <= req_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == wstq_pkg::ST_IDLE)
      else $error("result strobe while a command is still in progress");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PW'(SLOTS))
      else $error("pending count exceeds total queue capacity");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy raised without a start");

   a_read_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == wstq_pkg::ST_READ |-> $past(state_ff) == wstq_pkg::ST_PROBE)
      else $error("task read without a queue probe");

endmodule
